>>> rtl/lqr_balance_controller_defines.svh
// assertion macros shared by the lqr balance controller modules
`ifndef LQR_BALANCE_CONTROLLER_DEFINES_SVH
`define LQR_BALANCE_CONTROLLER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define LBC_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lbc check failed");

// when cond holds, nxt must hold in the following cycle
`define LBC_CHECK_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("lbc next-cycle check failed");

`endif

>>> rtl/lbc_pkg.sv
// shared types and constants of the lqr balance controller
`timescale 1ns / 1ps

package lbc_pkg;

	localparam int QDEPTH = 8;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	// gain*error is 64 bits, shifted right by 16 it fits 48 bits
	localparam int TERM_W = 48;
	localparam int PAIR_W = TERM_W + 1;
	localparam int U_W = TERM_W + 2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_VELOCITY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd6;

	typedef struct packed {
		logic signed [31:0] gain_pitch;
		logic signed [31:0] gain_pitch_rate;
		logic signed [31:0] gain_position;
		logic signed [31:0] gain_velocity;
		logic signed [31:0] gain_integral;
		logic [30:0]        max_drive;
		logic [30:0]        integral_limit;
	} lbc_cfg_t;

	// one classified word waiting for the integrator stage
	typedef struct packed {
		logic                  clear;
		logic                  enable;
		logic                  err_pos;
		logic                  err_neg;
		logic signed [U_W-1:0] u;
		logic signed [31:0]    delta;
		logic signed [63:0]    gain_delta;
	} lbc_item_t;

endpackage

>>> rtl/lqr_balance_controller.sv
// lqr balance controller top level: configuration registers and the two halves
//
// usage: an input word (in_valid/in_stall) carries measured pitch, pitch rate,
// position, velocity, their setpoints and time_step, or a clear action.
// each accepted word gives exactly one result word (out_valid/out_stall)
// with drive, integral_term and integrator_frozen, in order.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// writes it only while the block is idle, which the block does not enforce;
// indices beyond 6 are ignored. words pass front pipe, queue and back pipe.
// throughput: one word per cycle while out_stall is low and no rescale runs;
// the integrator update, wide adds and a compare against max_drive done as a
// word leaves the queue, sets that rate. a write to gain_integral starts a
// rescale pass (RS_MUL, then RS_LOAD) of the stored integrator product; no
// word leaves the queue while it runs, the front keeps accepting into it.
// reset: gains 0, limits at full scale, integrator 0, queue and pipes empty.
// when the receiver stalls, the output word holds, the back half holds and
// the 8 word queue fills; in_stall rises once queue plus front pipe hold 8.

`timescale 1ns / 1ps

module lqr_balance_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic signed [31:0]              pitch,
	input  logic signed [31:0]              pitch_rate,
	input  logic signed [31:0]              position,
	input  logic signed [31:0]              velocity,
	input  logic signed [31:0]              ref_pitch,
	input  logic signed [31:0]              ref_pitch_rate,
	input  logic signed [31:0]              ref_position,
	input  logic signed [31:0]              ref_velocity,
	input  logic [15:0]                     time_step,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              drive,
	output logic signed [31:0]              integral_term,
	output logic                            integrator_frozen
);
	import lbc_pkg::*;

	lbc_cfg_t        cfg_q;
	logic            gi_written;
	logic            push, pop, head_valid;
	lbc_item_t       push_item, head_item;
	logic [QCW-1:0]  q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_pitch <= '0;
			cfg_q.gain_pitch_rate <= '0;
			cfg_q.gain_position <= '0;
			cfg_q.gain_velocity <= '0;
			cfg_q.gain_integral <= '0;
			cfg_q.max_drive <= 31'h7fffffff;
			cfg_q.integral_limit <= 31'h7fffffff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_PITCH:      cfg_q.gain_pitch <= cfg_data;
				REG_GAIN_PITCH_RATE: cfg_q.gain_pitch_rate <= cfg_data;
				REG_GAIN_POSITION:   cfg_q.gain_position <= cfg_data;
				REG_GAIN_VELOCITY:   cfg_q.gain_velocity <= cfg_data;
				REG_GAIN_INTEGRAL:   cfg_q.gain_integral <= cfg_data;
				REG_MAX_DRIVE:       cfg_q.max_drive <= cfg_data[30:0];
				REG_INTEGRAL_LIMIT:  cfg_q.integral_limit <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	assign gi_written = cfg_we && (cfg_index == REG_GAIN_INTEGRAL);

	lbc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.pitch          (pitch),
		.pitch_rate     (pitch_rate),
		.position       (position),
		.velocity       (velocity),
		.ref_pitch      (ref_pitch),
		.ref_pitch_rate (ref_pitch_rate),
		.ref_position   (ref_position),
		.ref_velocity   (ref_velocity),
		.time_step      (time_step),
		.cfg            (cfg_q),
		.q_count        (q_count),
		.push           (push),
		.push_item      (push_item)
	);

	lbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.count      (q_count)
	);

	lbc_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg                   (cfg_q),
		.gain_integral_written (gi_written),
		.head_valid            (head_valid),
		.head_item             (head_item),
		.pop                   (pop),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.drive                 (drive),
		.integral_term         (integral_term),
		.integrator_frozen     (integrator_frozen)
	);

endmodule

>>> rtl/lbc_front.sv
// front pipeline: errors, gain products and proportional sum
`timescale 1ns / 1ps

module lbc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic signed [31:0]        pitch,
	input  logic signed [31:0]        pitch_rate,
	input  logic signed [31:0]        position,
	input  logic signed [31:0]        velocity,
	input  logic signed [31:0]        ref_pitch,
	input  logic signed [31:0]        ref_pitch_rate,
	input  logic signed [31:0]        ref_position,
	input  logic signed [31:0]        ref_velocity,
	input  logic [15:0]               time_step,
	input  lbc_pkg::lbc_cfg_t         cfg,
	input  logic [lbc_pkg::QCW-1:0]   q_count,
	output logic                      push,
	output lbc_pkg::lbc_item_t        push_item
);
	import lbc_pkg::*;

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			sat_sub = d[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			sat_sub = d[31:0];
		end
	endfunction

	logic                     accept;
	logic [QCW:0]             used;

	logic                     v_s1, v_s2, v_s3;
	logic                     clear_s1, clear_s2, clear_s3;
	logic signed [31:0]       ep_s1, er_s1, ex_s1, ev_s1;
	logic [15:0]              dt_s1;

	logic signed [63:0]       pr_pitch_s2, pr_rate_s2, pr_pos_s2, pr_vel_s2;
	logic signed [47:0]       pr_dt_s2;
	logic                     enable_s2, err_pos_s2, err_neg_s2;

	logic signed [PAIR_W-1:0] t01_s3, t23_s3;
	logic signed [31:0]       delta_s3;
	logic signed [63:0]       gid_s3;
	logic                     enable_s3, err_pos_s3, err_neg_s3;

	logic [TERM_W-1:0]        term_p, term_r, term_x, term_v;
	logic signed [31:0]       delta_c;

	// words in the pipe count against the queue so it can never overflow
	assign used = {1'b0, q_count} + {{QCW{1'b0}}, v_s1} + {{QCW{1'b0}}, v_s2}
		+ {{QCW{1'b0}}, v_s3};
	assign in_stall = used >= (QCW + 1)'(QDEPTH);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		term_p = pr_pitch_s2[63:16];
		term_r = pr_rate_s2[63:16];
		term_x = pr_pos_s2[63:16];
		term_v = pr_vel_s2[63:16];
		delta_c = pr_dt_s2[47:16];
	end

	always_ff @(posedge clk) begin
		clear_s1 <= action;
		ep_s1 <= sat_sub(pitch, ref_pitch);
		er_s1 <= sat_sub(pitch_rate, ref_pitch_rate);
		ex_s1 <= sat_sub(position, ref_position);
		ev_s1 <= sat_sub(velocity, ref_velocity);
		dt_s1 <= time_step;

		clear_s2 <= clear_s1;
		pr_pitch_s2 <= $signed(cfg.gain_pitch) * $signed(ep_s1);
		pr_rate_s2 <= $signed(cfg.gain_pitch_rate) * $signed(er_s1);
		pr_pos_s2 <= $signed(cfg.gain_position) * $signed(ex_s1);
		pr_vel_s2 <= $signed(cfg.gain_velocity) * $signed(ev_s1);
		pr_dt_s2 <= $signed(ep_s1) * $signed({1'b0, dt_s1});
		enable_s2 <= (cfg.gain_integral != 32'sd0) && (dt_s1 != 16'd0);
		err_pos_s2 <= !ep_s1[31] && (ep_s1 != 32'sd0);
		err_neg_s2 <= ep_s1[31];

		clear_s3 <= clear_s2;
		t01_s3 <= {term_p[TERM_W-1], term_p} + {term_r[TERM_W-1], term_r};
		t23_s3 <= {term_x[TERM_W-1], term_x} + {term_v[TERM_W-1], term_v};
		delta_s3 <= delta_c;
		gid_s3 <= $signed(cfg.gain_integral) * $signed(delta_c);
		enable_s3 <= enable_s2;
		err_pos_s3 <= err_pos_s2;
		err_neg_s3 <= err_neg_s2;
	end

	assign push = v_s3;

	always_comb begin
		push_item.clear = clear_s3;
		push_item.enable = enable_s3;
		push_item.err_pos = err_pos_s3;
		push_item.err_neg = err_neg_s3;
		push_item.u = {t01_s3[PAIR_W-1], t01_s3} + {t23_s3[PAIR_W-1], t23_s3};
		push_item.delta = delta_s3;
		push_item.gain_delta = gid_s3;
	end

endmodule

>>> rtl/lbc_queue.sv
// short word queue between the front pipeline and the integrator stage
`timescale 1ns / 1ps
`include "lqr_balance_controller_defines.svh"

module lbc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lbc_pkg::lbc_item_t      push_item,
	input  logic                    pop,
	output logic                    head_valid,
	output lbc_pkg::lbc_item_t      head_item,
	output logic [lbc_pkg::QCW-1:0] count
);
	import lbc_pkg::*;

	lbc_item_t       mem_q [QDEPTH];
	logic [QAW-1:0]  wr_q, rd_q;
	logic [QCW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	assign head_valid = count_q != '0;
	assign head_item = mem_q[rd_q];
	assign count = count_q;

	`LBC_CHECK(q_no_overflow, (count_q == QCW'(QDEPTH)) |-> !push)
	`LBC_CHECK(q_no_underflow, (count_q == '0) |-> !pop)
	`LBC_CHECK_NEXT(q_head_holds, head_valid && !pop, $stable(head_item))

endmodule

>>> rtl/lbc_back.sv
// back pipeline: integrator with anti-windup, clamps and output register
`timescale 1ns / 1ps
`include "lqr_balance_controller_defines.svh"

module lbc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lbc_pkg::lbc_cfg_t  cfg,
	input  logic               gain_integral_written,
	input  logic               head_valid,
	input  lbc_pkg::lbc_item_t head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive,
	output logic signed [31:0] integral_term,
	output logic               integrator_frozen
);
	import lbc_pkg::*;

	localparam logic [1:0] RS_IDLE = 2'd0;
	localparam logic [1:0] RS_MUL  = 2'd1;
	localparam logic [1:0] RS_LOAD = 2'd2;

	localparam int PROBE_W = U_W + 1;

	// integrator and its product with gain_integral, kept side by side
	logic signed [31:0]        integ_q;
	logic signed [63:0]        pacc_q, pmax_q, pmin_q, rsprod_q;
	logic [1:0]                rs_q;

	logic                      adv;
	logic signed [PROBE_W-1:0] probe, md_ext, md_neg;
	logic [32:0]               isum;
	logic                      hi, lo, frz;
	logic signed [31:0]        nxt_integ;
	logic signed [63:0]        nxt_pacc;
	logic signed [63:0]        gi_ext, gi_sh;

	logic                      v_s1, v_s2, v_s3;
	logic                      clear_s1, clear_s2;
	logic                      frozen_s1, frozen_s2, frozen_s3;
	logic signed [U_W-1:0]     u_s1, u_s2;
	logic signed [TERM_W-1:0]  pint_s1;
	logic signed [31:0]        iterm_s2, iterm_s3, drive_s3;

	logic signed [TERM_W-1:0]  lim_ext;
	logic signed [TERM_W-1:0]  iterm_c;
	logic signed [PROBE_W-1:0] sum_c;
	logic signed [PROBE_W-1:0] drive_c;

	assign adv = !(v_s3 && out_stall);
	assign pop = adv && head_valid && (rs_q == RS_IDLE);

	assign gi_ext = {{32{cfg.gain_integral[31]}}, cfg.gain_integral};
	assign gi_sh = gi_ext <<< 31;

	assign md_ext = {{(PROBE_W - 31){1'b0}}, cfg.max_drive};
	assign md_neg = -md_ext;

	always_comb begin
		probe = {head_item.u[U_W-1], head_item.u}
			+ {{(PROBE_W - TERM_W){pacc_q[63]}}, pacc_q[63:16]};
		hi = (probe >= md_ext) && head_item.err_pos;
		lo = (probe <= md_neg) && head_item.err_neg;
		isum = {integ_q[31], integ_q} + {head_item.delta[31], head_item.delta};
		nxt_integ = integ_q;
		nxt_pacc = pacc_q;
		frz = 1'b0;
		priority if (head_item.clear || !head_item.enable) begin
			nxt_integ = '0;
			nxt_pacc = '0;
		end else if (hi || lo) begin
			frz = 1'b1;
		end else if (isum[32] != isum[31]) begin
			// saturated sum: product comes from the precomputed end points
			if (isum[32]) begin
				nxt_integ = 32'sh80000000;
				nxt_pacc = pmin_q;
			end else begin
				nxt_integ = 32'sh7fffffff;
				nxt_pacc = pmax_q;
			end
		end else begin
			nxt_integ = isum[31:0];
			nxt_pacc = pacc_q + head_item.gain_delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			pacc_q <= '0;
			pmax_q <= '0;
			pmin_q <= '0;
			rs_q <= RS_IDLE;
		end else begin
			unique case (rs_q)
				RS_IDLE: begin
					if (gain_integral_written) begin
						rs_q <= RS_MUL;
					end
				end
				RS_MUL: begin
					pmax_q <= gi_sh - gi_ext;
					pmin_q <= -gi_sh;
					rs_q <= RS_LOAD;
				end
				RS_LOAD: begin
					pacc_q <= rsprod_q;
					rs_q <= RS_IDLE;
				end
				default: begin
					rs_q <= RS_IDLE;
				end
			endcase
			if (pop) begin
				integ_q <= nxt_integ;
				pacc_q <= nxt_pacc;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsprod_q <= $signed(cfg.gain_integral) * $signed(integ_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		lim_ext = {{(TERM_W - 31){1'b0}}, cfg.integral_limit};
		if (pint_s1 > lim_ext) begin
			iterm_c = lim_ext;
		end else if (pint_s1 < -lim_ext) begin
			iterm_c = -lim_ext;
		end else begin
			iterm_c = pint_s1;
		end
		sum_c = {u_s2[U_W-1], u_s2} + {{(PROBE_W - 32){iterm_s2[31]}}, iterm_s2};
		if (sum_c > md_ext) begin
			drive_c = md_ext;
		end else if (sum_c < md_neg) begin
			drive_c = md_neg;
		end else begin
			drive_c = sum_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clear_s1 <= head_item.clear;
			frozen_s1 <= frz;
			u_s1 <= head_item.u;
			pint_s1 <= nxt_pacc[63:16];

			clear_s2 <= clear_s1;
			frozen_s2 <= frozen_s1;
			u_s2 <= u_s1;
			iterm_s2 <= iterm_c[31:0];

			frozen_s3 <= frozen_s2;
			iterm_s3 <= iterm_s2;
			drive_s3 <= clear_s2 ? 32'sd0 : drive_c[31:0];
		end
	end

	assign out_valid = v_s3;
	assign drive = drive_s3;
	assign integral_term = iterm_s3;
	assign integrator_frozen = frozen_s3;

	`LBC_CHECK(rs_blocks_pop, (rs_q != RS_IDLE) |-> !pop)
	`LBC_CHECK_NEXT(clear_zeroes_state, pop && head_item.clear, integ_q == '0 && pacc_q == '0)
	`LBC_CHECK_NEXT(freeze_holds_state, pop && frz, $stable(integ_q) && $stable(pacc_q))

endmodule

>>> sim/lbc_drive_checker.sv
// checker for lqr_balance_controller: predicts each result word and compares it
`timescale 1ns / 1ps

module lbc_drive_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          action,
	input  logic [31:0]                   pitch,
	input  logic [31:0]                   pitch_rate,
	input  logic [31:0]                   position,
	input  logic [31:0]                   velocity,
	input  logic [31:0]                   ref_pitch,
	input  logic [31:0]                   ref_pitch_rate,
	input  logic [31:0]                   ref_position,
	input  logic [31:0]                   ref_velocity,
	input  logic [15:0]                   time_step,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [31:0]                   drive,
	input  logic [31:0]                   integral_term,
	input  logic                          integrator_frozen,
	output int                            mismatches,
	output int                            words_in_flight
);
	import lbc_pkg::*;

	localparam int REPORT_CAP = 200;

	typedef struct packed {
		logic        clear;
		logic [31:0] pitch;
		logic [31:0] pitch_rate;
		logic [31:0] position;
		logic [31:0] velocity;
		logic [31:0] sp_pitch;
		logic [31:0] sp_pitch_rate;
		logic [31:0] sp_position;
		logic [31:0] sp_velocity;
		logic [15:0] dt;
	} balance_cmd_t;

	typedef struct packed {
		logic [31:0] drive;
		logic [31:0] iterm;
		logic        frozen;
	} balance_res_t;

	lbc_cfg_t           gains;
	logic signed [31:0] integ_acc;
	balance_res_t       pending_results[$];
	int                 reported;

	function automatic longint sx(input logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// q16.16 product, floor rounding
	function automatic longint scaled(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint clamp_abs(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic balance_res_t balance_step(input balance_cmd_t c);
		longint ep, er, ex, ev, dt, u, probe, gi, md, acc, iterm, drv;
		balance_res_t r;
		r = '0;
		if (c.clear) begin
			integ_acc = '0;
			return r;
		end
		ep = sat32(sx(c.pitch) - sx(c.sp_pitch));
		er = sat32(sx(c.pitch_rate) - sx(c.sp_pitch_rate));
		ex = sat32(sx(c.position) - sx(c.sp_position));
		ev = sat32(sx(c.velocity) - sx(c.sp_velocity));
		dt = longint'(c.dt);
		u = scaled(sx(gains.gain_pitch), ep) + scaled(sx(gains.gain_pitch_rate), er)
			+ scaled(sx(gains.gain_position), ex) + scaled(sx(gains.gain_velocity), ev);
		gi = sx(gains.gain_integral);
		md = longint'(gains.max_drive);
		acc = sx(integ_acc);
		if (gi != 0 && dt != 0) begin
			// anti-windup looks at the drive with the old integrator
			probe = u + scaled(gi, acc);
			if ((probe >= md && ep > 0) || (probe <= -md && ep < 0))
				r.frozen = 1'b1;
			else
				acc = sat32(acc + scaled(ep, dt));
		end else begin
			acc = 0;
		end
		integ_acc = 32'(acc);
		iterm = clamp_abs(scaled(gi, acc), longint'(gains.integral_limit));
		drv = clamp_abs(u + iterm, md);
		r.drive = 32'(drv);
		r.iterm = 32'(iterm);
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got, inout int errs);
		if (got !== want) begin
			errs++;
			if (reported < REPORT_CAP)
				$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			reported++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		balance_cmd_t cmd;
		balance_res_t want;
		int errs;
		int moved;
		if (!arst_n) begin
			gains = '0;
			gains.max_drive = '1;
			gains.integral_limit = '1;
			integ_acc = '0;
			pending_results.delete();
			reported = 0;
			mismatches <= 0;
			words_in_flight <= 0;
		end else begin
			errs = 0;
			moved = 0;
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_PITCH:      gains.gain_pitch = cfg_data;
					REG_GAIN_PITCH_RATE: gains.gain_pitch_rate = cfg_data;
					REG_GAIN_POSITION:   gains.gain_position = cfg_data;
					REG_GAIN_VELOCITY:   gains.gain_velocity = cfg_data;
					REG_GAIN_INTEGRAL:   gains.gain_integral = cfg_data;
					REG_MAX_DRIVE:       gains.max_drive = cfg_data[30:0];
					REG_INTEGRAL_LIMIT:  gains.integral_limit = cfg_data[30:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				cmd.clear = action;
				cmd.pitch = pitch;
				cmd.pitch_rate = pitch_rate;
				cmd.position = position;
				cmd.velocity = velocity;
				cmd.sp_pitch = ref_pitch;
				cmd.sp_pitch_rate = ref_pitch_rate;
				cmd.sp_position = ref_position;
				cmd.sp_velocity = ref_velocity;
				cmd.dt = time_step;
				pending_results.push_back(balance_step(cmd));
				moved++;
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errs++;
					if (reported < REPORT_CAP)
						$error("result word with no expectation: drive %0d", $signed(drive));
					reported++;
				end else begin
					want = pending_results.pop_front();
					moved--;
					compare_field("drive", want.drive, drive, errs);
					compare_field("integral_term", want.iterm, integral_term, errs);
					compare_field("integrator_frozen", {31'd0, want.frozen},
						{31'd0, integrator_frozen}, errs);
				end
			end
			mismatches <= mismatches + errs;
			words_in_flight <= words_in_flight + moved;
		end
	end

endmodule

>>> sim/tb.sv
// testbench top for lqr_balance_controller: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
	import lbc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // decodes to nothing
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam int SETTLE = 10;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS = 203;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               action;
	logic signed [31:0] pitch, pitch_rate, position, velocity;
	logic signed [31:0] ref_pitch, ref_pitch_rate, ref_position, ref_velocity;
	logic [15:0]        time_step;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] drive;
	logic signed [31:0] integral_term;
	logic               integrator_frozen;
	int                 mismatches;
	int                 words_in_flight;
	int                 cycles = 0;
	bit                 calm = 1'b0;
	bit                 gaps_on = 1'b1;

	lqr_balance_controller DUT (.*);
	lbc_drive_checker drive_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** lqr_balance_controller: FAILED **");
			$finish;
		end
	end

	// receiver back-pressure in bursts, switched on and off in stretches
	initial begin
		bit stall_on;
		out_stall <= 1'b0;
		forever begin
			stall_on = !calm && $urandom_range(0, 2) != 0;
			repeat ($urandom_range(40, 160)) begin
				@(posedge clk);
				if (stall_on && !calm && $urandom_range(0, 4) == 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 10)) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	function automatic lbc_cfg_t settings(input logic [31:0] gp, gpr, gx, gv, gi,
			input logic [30:0] md, il);
		lbc_cfg_t s;
		s.gain_pitch = gp;
		s.gain_pitch_rate = gpr;
		s.gain_position = gx;
		s.gain_velocity = gv;
		s.gain_integral = gi;
		s.max_drive = md;
		s.integral_limit = il;
		return s;
	endfunction

	function automatic logic [31:0] pick_value(input bit tight);
		int unsigned sel;
		sel = $urandom_range(0, 15);
		if (tight && sel < 13)
			return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		case (sel)
			0: return MINV;
			1: return MAXV;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_dt();
		case ($urandom_range(0, 15))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// within +-2.0
	function automatic logic [31:0] small_gain();
		return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return MINV;
			1: return MAXV;
			2: return 32'h0;
			3: return 32'h1;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [30:0] pick_limit_extreme();
		case ($urandom_range(0, 2))
			0: return 31'h0;
			1: return 31'h1;
			default: return 31'h7FFF_FFFF;
		endcase
	endfunction

	function automatic lbc_cfg_t make_settings(input int style);
		case (style)
			0: return settings($urandom, $urandom, $urandom, $urandom, $urandom,
				31'($urandom), 31'($urandom));
			1: return settings(small_gain(), small_gain(), small_gain(), small_gain(),
				32'($urandom_range(0, 32'h0001_0000)) - 32'h0000_8000,
				31'($urandom_range(32'h0000_4000, 32'h0014_0000)),
				31'($urandom_range(0, 32'h000A_0000)));
			default: return settings(pick_extreme(), pick_extreme(), pick_extreme(),
				pick_extreme(), pick_extreme(), pick_limit_extreme(), pick_limit_extreme());
		endcase
	endfunction

	// leaves cfg_we high so back-to-back writes need one assignment per edge
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic write_settings(input lbc_cfg_t s);
		put_reg(REG_GAIN_PITCH, s.gain_pitch);
		put_reg(REG_GAIN_PITCH_RATE, s.gain_pitch_rate);
		put_reg(REG_GAIN_POSITION, s.gain_position);
		put_reg(REG_GAIN_VELOCITY, s.gain_velocity);
		put_reg(REG_GAIN_INTEGRAL, s.gain_integral);
		// top bit of the limits must be dropped by the block
		put_reg(REG_MAX_DRIVE, {1'($urandom_range(0, 1)), s.max_drive});
		put_reg(REG_INTEGRAL_LIMIT, {1'($urandom_range(0, 1)), s.integral_limit});
		put_reg(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input logic clr, input logic [31:0] p, pr, x, v, rp, rpr, rx, rv,
			input logic [15:0] dt);
		action <= clr;
		pitch <= p;
		pitch_rate <= pr;
		position <= x;
		velocity <= v;
		ref_pitch <= rp;
		ref_pitch_rate <= rpr;
		ref_position <= rx;
		ref_velocity <= rv;
		time_step <= dt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(input bit tight);
		if ($urandom_range(0, 24) == 0)
			send_word(1'b1, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, pick_dt());
		else
			send_word(1'b0, pick_value(tight), pick_value(tight), pick_value(tight),
				pick_value(tight), pick_value(tight), pick_value(tight),
				pick_value(tight), pick_value(tight), pick_dt());
	endtask

	task automatic maybe_gap();
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// call with in_valid already lowered
	task automatic drain();
		do @(posedge clk); while (words_in_flight != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		lbc_cfg_t s;
		bit tight;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= 1'b0;
		pitch <= '0;
		pitch_rate <= '0;
		position <= '0;
		velocity <= '0;
		ref_pitch <= '0;
		ref_pitch_rate <= '0;
		ref_position <= '0;
		ref_velocity <= '0;
		time_step <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: integrator disabled, all outputs zero
		send_word(1'b0, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, 16'hFFFF);
		in_valid <= 1'b0;
		drain();

		// gains 2.0, 0.5, -1.0, 0.25, ki 1.0, drive limit 10.0, integral limit 3.0
		write_settings(settings(32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_4000,
			32'h0001_0000, 31'h000A_0000, 31'h0003_0000));
		send_word(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000);
		maybe_gap();
		send_word(1'b0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 16'h8000);
		send_word(1'b0, 32'h0001_0000, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 16'h8000);
		// saturated pitch error, drive pinned high then low: integrator held
		send_word(1'b0, MAXV, 0, 0, 0, MINV, 0, 0, 0, 16'hFFFF);
		send_word(1'b0, MINV, 0, 0, 0, MAXV, 0, 0, 0, 16'hFFFF);
		// drive saturated but pitch error pulls back: keeps integrating
		send_word(1'b0, 32'hFFFF_0000, 0, 0, MAXV, 0, 0, 0, MINV, 16'h4000);
		send_word(1'b0, 32'h0001_0000, 0, 0, MINV, 0, 0, 0, MAXV, 16'h4000);
		maybe_gap();
		send_word(1'b1, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, 16'hFFFF);
		send_word(1'b0, 0, MAXV, MINV, 0, 0, MINV, MAXV, 0, 16'h0001);
		send_word(1'b0, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 16'hFFFF);
		send_word(1'b0, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 16'hFFFF);
		send_word(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000);
		// probe lands exactly on +-max_drive
		send_word(1'b0, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 16'h1000);
		send_word(1'b0, 32'hFFFB_0000, 0, 0, 0, 0, 0, 0, 0, 16'h1000);
		send_word(1'b0, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF);
		in_valid <= 1'b0;
		drain();

		// tiny ki, no limits: drive the integrator into both rails
		write_settings(settings(0, 0, 0, 0, 32'h0000_0001, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
		repeat (3) send_word(1'b0, MAXV, 0, 0, 0, MINV, 0, 0, 0, 16'hFFFF);
		repeat (3) send_word(1'b0, MINV, 0, 0, 0, MAXV, 0, 0, 0, 16'hFFFF);
		in_valid <= 1'b0;
		drain();

		// full-scale gains with both limits at zero
		write_settings(settings(MINV, MAXV, MINV, MAXV, MINV, 31'h0, 31'h0));
		repeat (3) send_random(1'b0);
		in_valid <= 1'b0;
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			s = make_settings(ph % 3);
			if (ph == 4)
				s.gain_integral = '0;
			write_settings(s);
			tight = (ph % 3 == 1) || ($urandom_range(0, 1) == 1);
			calm = (ph == RANDOM_PHASES - 1);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 64 == 0)
					gaps_on = $urandom_range(0, 2) != 0;
				send_random(tight);
				if (!calm && $urandom_range(0, 199) == 0) begin
					in_valid <= 1'b0;
					drain();
				end else begin
					maybe_gap();
				end
			end
			in_valid <= 1'b0;
			drain();
		end

		if (mismatches == 0)
			$display("** lqr_balance_controller: PASSED **");
		else
			$display("** lqr_balance_controller: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/lbc_pkg.sv
rtl/lbc_front.sv
rtl/lbc_queue.sv
rtl/lbc_back.sv
rtl/lqr_balance_controller.sv
sim/lbc_drive_checker.sv
sim/tb.sv
